FILE: sv/extended_float_multiply_unit_assert.svh
// Assertion macros for the extended float multiply unit.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef EXTENDED_FLOAT_MULTIPLY_UNIT_ASSERT_SVH
`define EXTENDED_FLOAT_MULTIPLY_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define EFM_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("efm check failed");

// next-cycle implication
`define EFM_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("efm check failed");

`endif

FILE: sv/efm_pkg.sv
// Package for the extended float multiply unit: constants and stage types.
// No dependencies.
`timescale 1ns / 1ps
package efm_pkg;
	localparam int unsigned ExpW  = 15;
	localparam int unsigned MantW = 64;
	localparam logic [ExpW-1:0] ExpMax = 15'h7FFF;
	// exponent sums kept as 17-bit signed: ea + eb - bias + 1 fits
	localparam logic signed [16:0] ExpBias = 17'sd16383;

	// side data carried alongside the partial products
	typedef struct packed {
		logic                   sign;
		logic                   zero;
		logic signed [16:0]     exp;
	} efm_side_t;
endpackage

FILE: sv/efm_mult.sv
// Pipelined 64x64 mantissa multiplier: four 32x32 partial products, then
// one 128-bit sum. Depends on efm_pkg. Two register stages, stall on en.
`timescale 1ns / 1ps
module efm_mult
	import efm_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [MantW-1:0]   a,
	input  logic [MantW-1:0]   b,
	output logic [2*MantW-1:0] prod
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= {p11_s1, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0};
		end
	end
endmodule

FILE: sv/efm_norm.sv
// Normalise and range-check the product: one-bit shift, overflow
// saturation, underflow flush, zero. Depends on efm_pkg. Combinational.
`timescale 1ns / 1ps
module efm_norm
	import efm_pkg::*;
(
	input  efm_side_t          side,
	input  logic [2*MantW-1:0] prod,
	output logic [ExpW-1:0]    exp_o,
	output logic [MantW-1:0]   mant_o,
	output logic               ovf_o,
	output logic               unf_o
);
	logic signed [16:0] e;
	logic [MantW-1:0]   m;

	always_comb begin
		if (prod[127]) begin
			m = prod[127:64];
			e = side.exp + 17'sd1;
		end else begin
			m = prod[126:63];
			e = side.exp;
		end
		exp_o  = e[ExpW-1:0];
		mant_o = m;
		ovf_o  = 1'b0;
		unf_o  = 1'b0;
		if (side.zero) begin
			exp_o  = '0;
			mant_o = '0;
		end else if (e >= 17'sd32767) begin
			exp_o  = ExpMax;
			mant_o = {1'b1, 63'd0};
			ovf_o  = 1'b1;
		end else if (e <= 17'sd0) begin
			exp_o  = '0;
			mant_o = '0;
			unf_o  = 1'b1;
		end
	end
endmodule

FILE: sv/extended_float_multiply_unit.sv
// Extended float multiply unit: the pipeline top level.
// Channels: in (a_*, b_*) and out (p_*, flags), each with valid/ready.
// A transfer on the input enters stage 1; the result reaches the output
// through four register stages: input, two multiplier stages and
// normalise/output. Throughput is one item per cycle while the receiver
// does not stall, set by the fully pipelined 32x32 partial-product
// multiplier. When the receiver stalls the whole pipeline
// holds; in_ready = out not valid or out ready, so nothing is lost or
// repeated. Reset clears all valid bits; payload registers are not reset.
// Zero operands give a signed zero; exponent overflow gives infinity with
// overflow set; underflow flushes to zero with underflow set.
// Infinity and NaN operands are treated as ordinary numbers.
// Depends on efm_pkg, efm_mult, efm_norm and the assertion header.
`timescale 1ns / 1ps
`include "extended_float_multiply_unit_assert.svh"
module extended_float_multiply_unit
	import efm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             a_sign,
	input  logic [ExpW-1:0]  a_exp,
	input  logic [MantW-1:0] a_mant,
	input  logic             b_sign,
	input  logic [ExpW-1:0]  b_exp,
	input  logic [MantW-1:0] b_mant,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             p_sign,
	output logic [ExpW-1:0]  p_exp,
	output logic [MantW-1:0] p_mant,
	output logic             overflow,
	output logic             underflow
);
	logic               en;
	logic               v_s1, v_s2, v_s3;
	logic [MantW-1:0]   a_s1, b_s1;
	efm_side_t          side_s1, side_s2, side_s3;
	logic [2*MantW-1:0] prod;
	logic [ExpW-1:0]    n_exp;
	logic [MantW-1:0]   n_mant;
	logic               n_ovf, n_unf;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1         <= a_mant;
			b_s1         <= b_mant;
			side_s1.sign <= a_sign ^ b_sign;
			side_s1.zero <= (a_mant == '0) || (b_mant == '0);
			side_s1.exp  <= 17'(signed'({2'b00, a_exp})) + 17'(signed'({2'b00, b_exp}))
				- ExpBias;
			side_s2      <= side_s1;
			side_s3      <= side_s2;
			p_sign       <= side_s3.sign;
			p_exp        <= n_exp;
			p_mant       <= n_mant;
			overflow     <= n_ovf;
			underflow    <= n_unf;
		end
	end

	efm_mult u_mult (
		.clk  (clk),
		.en   (en),
		.a    (a_s1),
		.b    (b_s1),
		.prod (prod)
	);

	efm_norm u_norm (
		.side   (side_s3),
		.prod   (prod),
		.exp_o  (n_exp),
		.mant_o (n_mant),
		.ovf_o  (n_ovf),
		.unf_o  (n_unf)
	);

	`EFM_ASSERT_IMPL(a_flags_excl, out_valid, !(overflow && underflow))
	`EFM_ASSERT_IMPL(a_ovf_inf, out_valid && overflow,
		p_exp == ExpMax && p_mant == {1'b1, 63'd0})
	`EFM_ASSERT_IMPL(a_unf_zero, out_valid && underflow, p_exp == '0 && p_mant == '0)
	`EFM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(p_mant))
endmodule
